[design/ucd_pkg.sv]
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants for the UTF-8 / CESU-8 character decoder.
// ----------------------------------------------------------------------------
package ucd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned WINDOW  = 6;

   localparam logic [CP_W-1:0] ERR_CODE_POINT = 21'h00003F;
   localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h110000;
   localparam logic [CP_W-1:0] SURR_FIRST     = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_LAST      = 21'h00DFFF;
   localparam logic [CP_W-1:0] NONCHAR_FIRST  = 21'h00FDD0;
   localparam logic [CP_W-1:0] NONCHAR_LAST   = 21'h00FDEF;
   localparam logic [15:0]     NONCHAR_TAIL   = 16'hFFFE;

   localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] PAIR_BASE      = 21'h010000;

   localparam logic [BYTE_W-1:0] CESU_LEAD    = 8'hED;
   localparam logic [3:0]        LOW_SURR_TOP = 4'hB;
   localparam logic [5:0]        HIGH_SURR_TOP = 6'b110110;

   localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;
   localparam logic [COUNT_W-1:0] LEN_PAIR  = 3'd6;

   typedef struct packed {
      logic       cont;
      logic [5:0] bits;
   } byte_info_type;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic               decode_error;
      logic [COUNT_W-1:0] bytes_used;
      logic               not_strict;
   } result_type;

endpackage

[design/ucd_byte_lane.sv]
// ----------------------------------------------------------------------------
// ucd_byte_lane
// Classify one window byte: continuation flag and six payload bits.
// ----------------------------------------------------------------------------
module ucd_byte_lane
   import ucd_pkg::*;
(
   input  logic [BYTE_W-1:0] data,
   output byte_info_type     info
);

   assign info.cont = (data[7:6] == 2'b10);
   assign info.bits = data[5:0];

endmodule

[design/ucd_scalar_check.sv]
// ----------------------------------------------------------------------------
// ucd_scalar_check
// Check one candidate code point against its minimum and the scalar rules.
// ----------------------------------------------------------------------------
module ucd_scalar_check
   import ucd_pkg::*;
(
   input  logic [CP_W-1:0] value,
   input  logic [CP_W-1:0] min_value,
   output logic            ok
);

   logic below_max;
   logic surrogate;
   logic nonchar_tail;
   logic nonchar_block;

   assign below_max     = (value < MAX_SCALAR);
   assign surrogate     = (value >= SURR_FIRST) && (value <= SURR_LAST);
   assign nonchar_tail  = (value[15:0] >= NONCHAR_TAIL);
   assign nonchar_block = (value >= NONCHAR_FIRST) && (value <= NONCHAR_LAST);

   assign ok = (value >= min_value) && below_max && !surrogate
               && !nonchar_tail && !nonchar_block;

endmodule

[design/ucd_merge.sv]
// ----------------------------------------------------------------------------
// ucd_merge
// Pick the sequence length from the lead byte and the lane flags, and
// combine the matching candidate into one result.
// ----------------------------------------------------------------------------
module ucd_merge
   import ucd_pkg::*;
(
   input  logic [BYTE_W-1:0]       lead,
   input  logic [BYTE_W-1:0]       third_byte,
   input  byte_info_type [WINDOW-1:0] info,
   input  logic [CP_W-1:0]         cand2,
   input  logic [CP_W-1:0]         cand3,
   input  logic [CP_W-1:0]         cand4,
   input  logic [CP_W-1:0]         cand6,
   input  logic                    ok2,
   input  logic                    ok3,
   input  logic                    ok4,
   input  logic                    ok6,
   output result_type              result
);

   logic good_lead;
   logic pair;

   // lead bytes C0..F7 open a multibyte sequence
   assign good_lead = (lead[7:6] == 2'b11) && (lead[7:3] != 5'b11111);

   // high surrogate followed by ED B0..BF xx
   assign pair = (cand3[15:10] == HIGH_SURR_TOP) && (third_byte == CESU_LEAD)
                 && (info[4].cont) && (info[4].bits[5:4] == LOW_SURR_TOP[1:0])
                 && info[5].cont;

   always_comb begin
      logic               err;
      logic [CP_W-1:0]    cp;
      logic [COUNT_W-1:0] len;
      err = 1'b0;
      cp  = {{(CP_W-BYTE_W){1'b0}}, lead};
      len = LEN_ONE;
      if (!lead[7]) begin
         err = 1'b0;
      end else if (!good_lead || !info[1].cont) begin
         err = 1'b1;
      end else if (!lead[5]) begin
         len = LEN_TWO;
         cp  = cand2;
         err = !ok2;
      end else if (!info[2].cont) begin
         len = LEN_TWO;
         err = 1'b1;
      end else if (!lead[4]) begin
         if (pair) begin
            len = LEN_PAIR;
            cp  = cand6;
            err = !ok6;
         end else begin
            len = LEN_THREE;
            cp  = cand3;
            err = !ok3;
         end
      end else if (!info[3].cont) begin
         len = LEN_THREE;
         err = 1'b1;
      end else begin
         len = LEN_FOUR;
         cp  = cand4;
         err = !ok4;
      end
      result.code_point   = err ? ERR_CODE_POINT : cp;
      result.decode_error = err;
      result.bytes_used   = len;
      result.not_strict   = err || (len == LEN_PAIR);
   end

endmodule

[design/utf8_cesu8_char_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_cesu8_char_decoder
// Decode one UTF-8 character (with CESU-8 surrogate pair folding) from a
// six-byte window per transaction.
// ----------------------------------------------------------------------------
// Response: an accepted request is decoded and appears in the response register in the next cycle.
// Throughput: one transaction per cycle while rsp_stall is low; a new request is taken while the
//   previous response is being drained, the response register sets the pace.
// Reset: synchronous, active high; clears the response valid flag only.
// ----------------------------------------------------------------------------
module utf8_cesu8_char_decoder
   import ucd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_byte0,
   input  logic [BYTE_W-1:0]   req_byte1,
   input  logic [BYTE_W-1:0]   req_byte2,
   input  logic [BYTE_W-1:0]   req_byte3,
   input  logic [BYTE_W-1:0]   req_byte4,
   input  logic [BYTE_W-1:0]   req_byte5,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_W-1:0]     rsp_code_point,
   output logic                rsp_decode_error,
   output logic [COUNT_W-1:0]  rsp_bytes_used,
   output logic                rsp_not_strict
);

   logic [BYTE_W-1:0]         window [WINDOW];
   byte_info_type [WINDOW-1:0] info;

   logic [CP_W-1:0] cand2;
   logic [CP_W-1:0] cand3;
   logic [CP_W-1:0] cand4;
   logic [CP_W-1:0] cand6;
   logic            ok2;
   logic            ok3;
   logic            ok4;
   logic            ok6;

   result_type rsp_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       load;

   assign window[0] = req_byte0;
   assign window[1] = req_byte1;
   assign window[2] = req_byte2;
   assign window[3] = req_byte3;
   assign window[4] = req_byte4;
   assign window[5] = req_byte5;

   // One classifier lane per window byte.
   for (genvar g = 0; g < WINDOW; g++) begin : g_lane
      ucd_byte_lane u_lane (
         .data (window[g]),
         .info (info[g])
      );
   end

   // Candidate code points, one per possible sequence length. Each one is
   // built as if the lead byte announced that length; the merge picks one.
   assign cand2 = {10'd0, req_byte0[4:0], info[1].bits};
   assign cand3 = {5'd0, req_byte0[3:0], info[1].bits, info[2].bits};
   assign cand4 = {req_byte0[2:0], info[1].bits, info[2].bits, info[3].bits};
   // Surrogate pair: ten bits from the high half, four from the low
   // surrogate's middle byte, six from its last byte, offset by 0x10000.
   assign cand6 = PAIR_BASE + {1'b0, cand3[9:0], req_byte4[3:0], info[5].bits};

   // Scalar validity check, one copy per candidate, all in parallel.
   ucd_scalar_check u_chk2 (.value(cand2), .min_value(MIN_TWO_BYTE),   .ok(ok2));
   ucd_scalar_check u_chk3 (.value(cand3), .min_value(MIN_THREE_BYTE), .ok(ok3));
   ucd_scalar_check u_chk4 (.value(cand4), .min_value(MIN_FOUR_BYTE),  .ok(ok4));
   ucd_scalar_check u_chk6 (.value(cand6), .min_value(MIN_FOUR_BYTE),  .ok(ok6));

   ucd_merge u_merge (
      .lead       (req_byte0),
      .third_byte (req_byte3),
      .info       (info),
      .cand2      (cand2),
      .cand3      (cand3),
      .cand4      (cand4),
      .cand6      (cand6),
      .ok2        (ok2),
      .ok3        (ok3),
      .ok4        (ok4),
      .ok6        (ok6),
      .result     (rsp_in)
   );

   // Response register: load whenever it is empty or being drained this
   // cycle, hold while the downstream side stalls a pending transaction.
   assign load         = !(rsp_valid_ff && rsp_stall);
   assign req_stall    = !load;
   assign rsp_valid_in = load ? req_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = rsp_ff.code_point;
   assign rsp_decode_error = rsp_ff.decode_error;
   assign rsp_bytes_used   = rsp_ff.bytes_used;
   assign rsp_not_strict   = rsp_ff.not_strict;

endmodule

[design/ucd_checker.sv]
// ----------------------------------------------------------------------------
// ucd_checker
// Port-level checks for the character decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ucd_checker
   import ucd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CP_W-1:0]    rsp_code_point,
   input logic               rsp_decode_error,
   input logic [COUNT_W-1:0] rsp_bytes_used,
   input logic               rsp_not_strict
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_bytes_used) && $stable(rsp_decode_error))
      else $error("stalled response changed");

   // every accepted request shows up as a response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   a_err_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_error |-> rsp_code_point == ERR_CODE_POINT)
      else $error("error response without replacement code point");

   a_strict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_not_strict == (rsp_decode_error || rsp_bytes_used == LEN_PAIR))
      else $error("strictness flag mismatch");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes_used == LEN_ONE || rsp_bytes_used == LEN_TWO
         || rsp_bytes_used == LEN_THREE || rsp_bytes_used == LEN_FOUR
         || rsp_bytes_used == LEN_PAIR)
      else $error("illegal byte count");

endmodule

bind utf8_cesu8_char_decoder ucd_checker u_ucd_checker (.*);
